/* design/mcpf_pkg.sv */
`timescale 1ns / 1ps
// package for the multi-channel pipe fifo
// types, constants and codes shared by the front, queue and back modules
package mcpf_pkg;

  localparam int Channels     = 32;
  localparam int BufferBytes  = 4096;
  localparam int MaxReadBurst = 16;
  localparam int ChW          = $clog2(Channels);
  localparam int PtrW         = $clog2(BufferBytes);
  localparam int FillW        = PtrW + 1;
  localparam int AddrW        = ChW + PtrW;
  localparam int MemDepth     = Channels * BufferBytes;
  localparam int BurstW       = $clog2(MaxReadBurst + 1);
  localparam int QDepth       = 4;
  localparam int QPtrW        = $clog2(QDepth);

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_CLOSE_RD  = 3'd3,
    OP_CLOSE_WR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD       = 3'd1,
    ST_BROKEN    = 3'd2,
    ST_FULL      = 3'd3,
    ST_BLOCK     = 3'd4,
    ST_EOF       = 3'd5,
    ST_NO_SLOT   = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    BK_IDLE  = 1'b0,
    BK_BURST = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] channel;
    logic [7:0] write_byte;
    logic [4:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [4:0]  channel_out;
    logic [31:0] read_handle;
    logic [31:0] write_handle;
    logic        last;
  } out_item_t;

  // classified job passed from front to back
  typedef struct packed {
    logic              is_read;
    logic              is_write;
    logic [2:0]        status;
    logic [4:0]        channel_out;
    logic [31:0]       read_handle;
    logic [7:0]        write_byte;
    logic [AddrW-1:0]  addr;
    logic [BurstW-1:0] count;
  } job_t;

endpackage

/* design/mcpf_front.sv */
`timescale 1ns / 1ps
// front end: accepts beats, checks the channel table, updates pointers
// depends on mcpf_pkg
module mcpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mcpf_pkg::in_item_t  in_data_i,
  output logic                job_valid_o,
  input  logic                job_stall_i,
  output mcpf_pkg::job_t      job_o
);

  logic [mcpf_pkg::PtrW-1:0]  rp_q [mcpf_pkg::Channels];
  logic [mcpf_pkg::PtrW-1:0]  wp_q [mcpf_pkg::Channels];
  logic [mcpf_pkg::FillW-1:0] fill_q [mcpf_pkg::Channels];
  logic [mcpf_pkg::Channels-1:0] used_q, rdone_q, wdone_q;
  logic [31:0] handle_q;

  logic fire;
  logic chan_ok;
  logic [mcpf_pkg::ChW-1:0] ch;
  logic [mcpf_pkg::ChW-1:0] free_idx;
  logic free_found;
  logic [mcpf_pkg::BurstW-1:0] n;
  logic [mcpf_pkg::FillW-1:0] req;
  mcpf_pkg::job_t job;

  assign in_stall_o  = job_stall_i;
  assign job_valid_o = in_valid_i;
  assign fire        = in_valid_i && !job_stall_i;
  assign ch          = in_data_i.channel[mcpf_pkg::ChW-1:0];
  assign chan_ok     = (in_data_i.channel < 6'(mcpf_pkg::Channels)) && used_q[ch];

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = mcpf_pkg::Channels - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx   = mcpf_pkg::ChW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    req = (in_data_i.byte_count == '0) ? mcpf_pkg::FillW'(1)
                                       : mcpf_pkg::FillW'(in_data_i.byte_count);
    if (req > fill_q[ch]) req = fill_q[ch];
    if (req > mcpf_pkg::FillW'(mcpf_pkg::MaxReadBurst))
      req = mcpf_pkg::FillW'(mcpf_pkg::MaxReadBurst);
    n = mcpf_pkg::BurstW'(req);
  end

  always_comb begin
    job             = '0;
    job.channel_out = 5'(in_data_i.channel);
    job.write_byte  = in_data_i.write_byte;
    job.count       = mcpf_pkg::BurstW'(1);
    job.status      = mcpf_pkg::ST_OK;
    if (in_data_i.op == mcpf_pkg::OP_CREATE) begin
      if (free_found) begin
        job.channel_out = 5'(free_idx);
        job.read_handle = handle_q;
      end else begin
        job.channel_out = '0;
        job.status      = mcpf_pkg::ST_NO_SLOT;
      end
    end else if (in_data_i.op > mcpf_pkg::OP_CLOSE_WR || !chan_ok) begin
      job.status = mcpf_pkg::ST_BAD;
    end else if (in_data_i.op == mcpf_pkg::OP_WRITE) begin
      if (rdone_q[ch]) job.status = mcpf_pkg::ST_BROKEN;
      else if (fill_q[ch] >= mcpf_pkg::FillW'(mcpf_pkg::BufferBytes))
        job.status = mcpf_pkg::ST_FULL;
      else begin
        job.is_write = 1'b1;
        job.addr     = {ch, wp_q[ch]};
      end
    end else if (in_data_i.op == mcpf_pkg::OP_READ) begin
      if (fill_q[ch] == '0) begin
        job.status = wdone_q[ch] ? mcpf_pkg::ST_EOF : mcpf_pkg::ST_BLOCK;
      end else begin
        job.is_read = 1'b1;
        job.addr    = {ch, rp_q[ch]};
        job.count   = n;
      end
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      rdone_q  <= '0;
      wdone_q  <= '0;
      handle_q <= 32'd3;
      for (int i = 0; i < mcpf_pkg::Channels; i++) begin
        rp_q[i]   <= '0;
        wp_q[i]   <= '0;
        fill_q[i] <= '0;
      end
    end else if (fire) begin
      if (in_data_i.op == mcpf_pkg::OP_CREATE && free_found) begin
        used_q[free_idx]  <= 1'b1;
        rdone_q[free_idx] <= 1'b0;
        wdone_q[free_idx] <= 1'b0;
        rp_q[free_idx]    <= '0;
        wp_q[free_idx]    <= '0;
        fill_q[free_idx]  <= '0;
        handle_q          <= handle_q + 32'd2;
      end else if (job.is_write) begin
        wp_q[ch]   <= wp_q[ch] + mcpf_pkg::PtrW'(1);
        fill_q[ch] <= fill_q[ch] + mcpf_pkg::FillW'(1);
      end else if (job.is_read) begin
        rp_q[ch]   <= rp_q[ch] + mcpf_pkg::PtrW'(n);
        fill_q[ch] <= fill_q[ch] - mcpf_pkg::FillW'(n);
      end else if (chan_ok && job.status == mcpf_pkg::ST_OK &&
                   (in_data_i.op == mcpf_pkg::OP_CLOSE_RD ||
                    in_data_i.op == mcpf_pkg::OP_CLOSE_WR)) begin
        if (in_data_i.op == mcpf_pkg::OP_CLOSE_RD) begin
          rdone_q[ch] <= 1'b1;
          if (wdone_q[ch]) used_q[ch] <= 1'b0;
        end else begin
          wdone_q[ch] <= 1'b1;
          if (rdone_q[ch]) used_q[ch] <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job.is_read |-> !job.is_write)
    else $error("read and write at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job.is_read |-> job.count != '0)
    else $error("empty read burst");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_data_i.op == mcpf_pkg::OP_CREATE && free_found
    |=> handle_q == $past(handle_q) + 32'd2)
    else $error("handle step");

endmodule

/* design/mcpf_queue.sv */
`timescale 1ns / 1ps
// short job queue between front and back
// depends on mcpf_pkg
module mcpf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  mcpf_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output mcpf_pkg::job_t rd_data_o
);

  mcpf_pkg::job_t mem_q [mcpf_pkg::QDepth];
  logic [mcpf_pkg::QPtrW-1:0] head_q, tail_q;
  logic [mcpf_pkg::QPtrW:0]   cnt_q;
  logic push, pop;

  assign wr_stall_o = (cnt_q == (mcpf_pkg::QPtrW+1)'(mcpf_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[head_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[tail_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) tail_q <= tail_q + mcpf_pkg::QPtrW'(1);
      if (pop)  head_q <= head_q + mcpf_pkg::QPtrW'(1);
      cnt_q <= cnt_q + (mcpf_pkg::QPtrW+1)'(push) - (mcpf_pkg::QPtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (mcpf_pkg::QPtrW+1)'(mcpf_pkg::QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + (mcpf_pkg::QPtrW+1)'(1))
    else $error("queue count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - (mcpf_pkg::QPtrW+1)'(1))
    else $error("queue count");

endmodule

/* design/mcpf_back.sv */
`timescale 1ns / 1ps
// back end: ring memory, read bursts and output register
// depends on mcpf_pkg
module mcpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_stall_o,
  input  mcpf_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mcpf_pkg::out_item_t out_data_o
);

  logic [7:0] ring_q [mcpf_pkg::MemDepth];

  mcpf_pkg::back_state_e state_q, state_d;
  mcpf_pkg::job_t        cur_q;
  logic [mcpf_pkg::BurstW-1:0] left_q;
  logic [mcpf_pkg::PtrW-1:0]   ptr_q;
  logic [7:0] rdata_q;
  logic       ovalid_q;
  mcpf_pkg::out_item_t odata_q;
  logic       rvalid_q;
  logic       obuf_free;
  logic       take_job, issue_rd;

  // output reg free this cycle (empty or being drained); read data slot one deep
  assign obuf_free   = !ovalid_q || !out_stall_i;
  assign take_job    = (state_q == mcpf_pkg::BK_IDLE) && job_valid_i && !rvalid_q && obuf_free;
  assign job_stall_o = !take_job;
  assign issue_rd    = (state_q == mcpf_pkg::BK_BURST) && !rvalid_q && left_q != '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcpf_pkg::BK_IDLE:  if (take_job && job_i.is_read) state_d = mcpf_pkg::BK_BURST;
      mcpf_pkg::BK_BURST: if (rvalid_q && obuf_free && left_q == '0)
                            state_d = mcpf_pkg::BK_IDLE;
      default:            state_d = mcpf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_job && job_i.is_write) ring_q[job_i.addr] <= job_i.write_byte;
    if (issue_rd) rdata_q <= ring_q[{cur_q.addr[mcpf_pkg::AddrW-1:mcpf_pkg::PtrW], ptr_q}];
  end

  always_ff @(posedge clk_i) begin
    if (take_job) begin
      cur_q  <= job_i;
      ptr_q  <= job_i.addr[mcpf_pkg::PtrW-1:0];
      left_q <= job_i.count;
    end else if (issue_rd) begin
      ptr_q  <= ptr_q + mcpf_pkg::PtrW'(1);
      left_q <= left_q - mcpf_pkg::BurstW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mcpf_pkg::BK_IDLE;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue_rd) rvalid_q <= 1'b1;
      else if (rvalid_q && obuf_free) rvalid_q <= 1'b0;
      if (take_job && !job_i.is_read) ovalid_q <= 1'b1;
      else if (rvalid_q && obuf_free) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_job && !job_i.is_read) begin
      odata_q.status       <= job_i.status;
      odata_q.read_byte    <= '0;
      odata_q.channel_out  <= job_i.channel_out;
      odata_q.read_handle  <= job_i.read_handle;
      odata_q.write_handle <= (job_i.status == mcpf_pkg::ST_OK && job_i.read_handle != '0)
                              ? job_i.read_handle + 32'd1 : 32'd0;
      odata_q.last         <= 1'b1;
    end else if (rvalid_q && obuf_free) begin
      odata_q.status       <= mcpf_pkg::ST_OK;
      odata_q.read_byte    <= rdata_q;
      odata_q.channel_out  <= cur_q.channel_out;
      odata_q.read_handle  <= '0;
      odata_q.write_handle <= '0;
      odata_q.last         <= (left_q == '0);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_rd |-> state_q == mcpf_pkg::BK_BURST)
    else $error("read outside burst");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_job |-> !rvalid_q)
    else $error("job taken with read pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q && $stable(odata_q))
    else $error("result lost under stall");

endmodule

/* design/multi_channel_pipe_fifo.sv */
`timescale 1ns / 1ps
// multi-channel pipe fifo: 32 byte rings of 4096 entries each
// input beats carry op, channel, write byte and byte count; output beats
// carry status, read byte, channel, two handles and a last flag.
// the front checks the channel table and moves pointers in the cycle a beat
// is accepted; a four-entry job queue feeds the back, which owns the ring
// memory and the output register.
// a result leaves through the job queue, the back and its output register;
// read bytes also pass the registered read data slot on their way out.
// the back takes a new create, write or close job while the last result
// drains unless the output stalls; a read holds it for its whole burst, paced by
// the single memory read port and the one-deep data slot ahead of the output.
// reset clears all channels to free, the handle counter to three and the
// queue; the ring contents are not cleared and need no clearing pass.
// a stalled output holds its beat; the back stops, the queue fills and then
// the input sees stall.
module multi_channel_pipe_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcpf_pkg::in_item_t  in_data_i,
  output logic                out_valid,
  input  logic                out_stall,
  output mcpf_pkg::out_item_t out_data_o
);

  logic           fj_valid, fj_stall, bj_valid, bj_stall;
  mcpf_pkg::job_t fj_data, bj_data;

  mcpf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i,
    .job_valid_o(fj_valid), .job_stall_i(fj_stall), .job_o(fj_data)
  );

  mcpf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_stall_o(fj_stall), .wr_data_i(fj_data),
    .rd_valid_o(bj_valid), .rd_stall_i(bj_stall), .rd_data_o(bj_data)
  );

  mcpf_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_stall_o(bj_stall), .job_i(bj_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o
  );

endmodule

/* tb/sv/tb_multi_channel_pipe_fifo.sv */
`timescale 1ns / 1ps
// self-checking testbench for multi_channel_pipe_fifo
// a pipe-table predictor in a small scoreboard class checks every output beat;
// depends on mcpf_pkg and the multi_channel_pipe_fifo top level
module tb_multi_channel_pipe_fifo;

  class pipe_table_sb;
    logic [7:0]  ring [mcpf_pkg::Channels][mcpf_pkg::BufferBytes];
    int unsigned rd_ptr [mcpf_pkg::Channels];
    int unsigned wr_ptr [mcpf_pkg::Channels];
    int unsigned fill [mcpf_pkg::Channels];
    bit          busy [mcpf_pkg::Channels];
    bit          rd_closed [mcpf_pkg::Channels];
    bit          wr_closed [mcpf_pkg::Channels];
    logic [31:0] handle_ctr;
    mcpf_pkg::out_item_t pending [$];
    int          errors;

    function new();
      handle_ctr = 32'd3;
      errors = 0;
      for (int c = 0; c < mcpf_pkg::Channels; c++) begin
        rd_ptr[c] = 0; wr_ptr[c] = 0; fill[c] = 0;
        busy[c] = 0; rd_closed[c] = 0; wr_closed[c] = 0;
      end
    endfunction

    function void push(mcpf_pkg::status_e st, logic [7:0] b, logic [4:0] ch,
                       logic [31:0] rh, logic [31:0] wh, logic lst);
      mcpf_pkg::out_item_t r;
      r.status = st; r.read_byte = b; r.channel_out = ch;
      r.read_handle = rh; r.write_handle = wh; r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_input(mcpf_pkg::in_item_t it);
      int ch;
      int n;
      bit found;
      ch = it.channel;
      found = 0;
      if (it.op == mcpf_pkg::OP_CREATE) begin
        for (int c = 0; c < mcpf_pkg::Channels && !found; c++) begin
          if (!busy[c]) begin
            found = 1;
            busy[c] = 1; rd_closed[c] = 0; wr_closed[c] = 0;
            rd_ptr[c] = 0; wr_ptr[c] = 0; fill[c] = 0;
            push(mcpf_pkg::ST_OK, 0, c[4:0], handle_ctr, handle_ctr + 32'd1, 1);
            handle_ctr = handle_ctr + 32'd2;
          end
        end
        if (!found) push(mcpf_pkg::ST_NO_SLOT, 0, 0, 0, 0, 1);
      end else if (it.op > mcpf_pkg::OP_CLOSE_WR || ch >= mcpf_pkg::Channels || !busy[ch]) begin
        push(mcpf_pkg::ST_BAD, 0, it.channel[4:0], 0, 0, 1);
      end else if (it.op == mcpf_pkg::OP_WRITE) begin
        if (rd_closed[ch]) push(mcpf_pkg::ST_BROKEN, 0, ch[4:0], 0, 0, 1);
        else if (fill[ch] >= mcpf_pkg::BufferBytes) push(mcpf_pkg::ST_FULL, 0, ch[4:0], 0, 0, 1);
        else begin
          ring[ch][wr_ptr[ch]] = it.write_byte;
          wr_ptr[ch] = (wr_ptr[ch] + 1) % mcpf_pkg::BufferBytes;
          fill[ch]++;
          push(mcpf_pkg::ST_OK, 0, ch[4:0], 0, 0, 1);
        end
      end else if (it.op == mcpf_pkg::OP_READ) begin
        if (fill[ch] == 0) begin
          push(wr_closed[ch] ? mcpf_pkg::ST_EOF : mcpf_pkg::ST_BLOCK, 0, ch[4:0], 0, 0, 1);
        end else begin
          n = (it.byte_count == 0) ? 1 : it.byte_count;
          if (n > fill[ch]) n = fill[ch];
          if (n > mcpf_pkg::MaxReadBurst) n = mcpf_pkg::MaxReadBurst;
          for (int i = 0; i < n; i++) begin
            push(mcpf_pkg::ST_OK, ring[ch][rd_ptr[ch]], ch[4:0], 0, 0, i == n - 1);
            rd_ptr[ch] = (rd_ptr[ch] + 1) % mcpf_pkg::BufferBytes;
          end
          fill[ch] -= n;
        end
      end else begin
        if (it.op == mcpf_pkg::OP_CLOSE_RD) rd_closed[ch] = 1;
        else wr_closed[ch] = 1;
        if (rd_closed[ch] && wr_closed[ch]) busy[ch] = 0;
        push(mcpf_pkg::ST_OK, 0, ch[4:0], 0, 0, 1);
      end
    endfunction

    function void check_result(mcpf_pkg::out_item_t got);
      mcpf_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.read_byte !== exp.read_byte ||
          got.channel_out !== exp.channel_out || got.read_handle !== exp.read_handle ||
          got.write_handle !== exp.write_handle || got.last !== exp.last) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  mcpf_pkg::in_item_t  in_data_i;
  logic                out_valid;
  logic                out_stall;
  mcpf_pkg::out_item_t out_data_o;

  pipe_table_sb sb;
  int          burst_left;
  bit          stall_quiet;
  int          open_chans [$];

  multi_channel_pipe_fifo u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data_i (in_data_i),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_multi_channel_pipe_fifo NOT OK");
    $finish;
  end

  // receiver stall pattern: quiet stretches alternate with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_quiet = ~stall_quiet;
      out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data_o);
  end

  // a new burst always starts after an idle gap with in_valid low
  task automatic send_beat(mcpf_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic send_op(mcpf_pkg::op_e op, logic [5:0] ch, logic [7:0] b, logic [4:0] n);
    mcpf_pkg::in_item_t it;
    it.op = op; it.channel = ch; it.write_byte = b; it.byte_count = n;
    send_beat(it);
  endtask

  task automatic drain();
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_beat();
    mcpf_pkg::in_item_t it;
    int pick;
    int ch;
    pick = $urandom_range(0, 99);
    ch = open_chans.size() ? open_chans[$urandom_range(0, open_chans.size() - 1)]
                           : $urandom_range(0, 31);
    it.write_byte = 8'($urandom_range(0, 255));
    it.byte_count = 5'($urandom_range(0, 31));
    it.channel = 6'(ch);
    if (pick < 6) it.op = mcpf_pkg::OP_CREATE;
    else if (pick < 55) it.op = mcpf_pkg::OP_WRITE;
    else if (pick < 80) it.op = mcpf_pkg::OP_READ;
    else if (pick < 85) it.op = mcpf_pkg::OP_CLOSE_RD;
    else if (pick < 90) it.op = mcpf_pkg::OP_CLOSE_WR;
    else if (pick < 95) begin
      it.op = mcpf_pkg::op_e'($urandom_range(0, 7));
      it.channel = 6'($urandom_range(0, 63));
    end else it.op = mcpf_pkg::op_e'($urandom_range(5, 7));
    send_beat(it);
    if (it.op == mcpf_pkg::OP_CREATE && sb.pending[$].status == mcpf_pkg::ST_OK)
      open_chans.push_back(sb.pending[$].channel_out);
  endtask

  initial begin
    sb = new();
    stall_quiet = 0;
    burst_left = 0;
    rst_ni = 0;
    in_valid = 0;
    in_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad channel, create, empty read, writes, reads, closes
    send_op(mcpf_pkg::OP_WRITE, 6'd63, 8'hff, 5'd31);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd1);
    send_op(mcpf_pkg::op_e'(3'd7), 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_CREATE, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_CREATE, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd4);
    for (int i = 0; i < 6; i++) send_op(mcpf_pkg::OP_WRITE, 6'd0, 8'(i * 51), 5'd0);
    send_op(mcpf_pkg::OP_WRITE, 6'd1, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd16);
    send_op(mcpf_pkg::OP_CLOSE_WR, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd1);
    send_op(mcpf_pkg::OP_CLOSE_WR, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_CLOSE_RD, 6'd1, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_WRITE, 6'd1, 8'haa, 5'd0);
    send_op(mcpf_pkg::OP_CLOSE_RD, 6'd0, 8'h00, 5'd0);
    send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'd1);
    send_op(mcpf_pkg::OP_CLOSE_WR, 6'd1, 8'h00, 5'd0);
    drain();

    // fill every slot to hit no free slot, then free a few
    for (int i = 0; i < mcpf_pkg::Channels + 1; i++)
      send_op(mcpf_pkg::OP_CREATE, 6'd0, 8'h00, 5'd0);
    for (int i = 1; i < 4; i++) begin
      send_op(mcpf_pkg::OP_CLOSE_RD, 6'(i), 8'h00, 5'd0);
      send_op(mcpf_pkg::OP_CLOSE_WR, 6'(i), 8'h00, 5'd0);
    end
    send_op(mcpf_pkg::OP_READ, 6'd32, 8'h00, 5'd2);
    drain();

    open_chans.push_back(0);
    for (int i = 0; i < 25; i++) random_beat();
    drain();
    // long reads through a well-filled channel
    for (int i = 0; i < 12; i++)
      send_op(mcpf_pkg::OP_WRITE, 6'd0, 8'($urandom_range(0, 255)), 5'd0);
    for (int i = 0; i < 3; i++)
      send_op(mcpf_pkg::OP_READ, 6'd0, 8'h00, 5'($urandom_range(0, 31)));
    for (int i = 0; i < 8; i++) random_beat();
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_multi_channel_pipe_fifo OK");
    end else begin
      $display("tb_multi_channel_pipe_fifo NOT OK");
    end
    $finish;
  end
endmodule

/* multi_channel_pipe_fifo.f */
design/mcpf_pkg.sv
design/mcpf_front.sv
design/mcpf_queue.sv
design/mcpf_back.sv
design/multi_channel_pipe_fifo.sv
tb/sv/tb_multi_channel_pipe_fifo.sv
